[rtl/itt_pkg.sv]
// Shared types and constants for the three-channel interval timer.
// Used by itt_chan.sv and interval_timer_three_channel.sv; no dependencies.
package itt_pkg;

  localparam int unsigned NumChan = 3;

  // Byte returned when there is nothing to read
  localparam logic [7:0] BYTE_NONE = 8'hFF;

  // Port that addresses the control word register
  localparam logic [1:0] CW_PORT = 2'd3;

  // Select code of the read-back command in a control word
  localparam logic [1:0] SEL_READBACK = 2'd3;

  // Access mode code of the counter-latch command
  localparam logic [1:0] ACC_LATCH = 2'd0;

  // Command carried by an input word
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_SPKR  = 2'd3
  } cmd_e;

  // Per-word strobes from the decoder to one channel
  typedef struct packed {
    logic       tick;
    logic       data_wr;
    logic       data_rd;
    logic       cw_prog;
    logic       cnt_latch;
    logic       sts_latch;
    logic [7:0] wdata;
  } chan_ctl_t;

  // What one channel reports back for the current word
  typedef struct packed {
    logic [7:0] rdata;
    logic       level;
    logic       wrap;
    logic       load;
    logic [2:0] eff_mode;
  } chan_sts_t;

endpackage

[rtl/itt_chan.sv]
// One timer channel: reload, down counter, mode, byte sequencing and latches.
// Depends on itt_pkg for the strobe and status structs.
module itt_chan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itt_pkg::chan_ctl_t ctl_i,
  output itt_pkg::chan_sts_t sts_o
);
  import itt_pkg::*;

  logic [16:0] reload_q, reload_d;
  logic [15:0] down_q, down_d;
  logic [2:0]  mode_q, mode_d;
  logic        bcd_q, bcd_d;
  logic [1:0]  acc_q, acc_d;
  logic [1:0]  wph_q, wph_d;
  logic [1:0]  rph_q, rph_d;
  logic [7:0]  low_q, low_d;
  logic [3:0]  lf_q, lf_d;
  logic [7:0]  shold_q, shold_d;
  logic [15:0] chold_q, chold_d;

  logic [2:0]  eff_mode;
  logic [16:0] phase;
  logic [17:0] rel_p1;
  logic [16:0] rel_m1;
  logic        level;
  logic [15:0] load_val;
  logic        do_load;
  logic [7:0]  rdata;

  // Fold modes six and seven onto two and three
  assign eff_mode = (mode_q >= 3'd6) ? (mode_q - 3'd4) : mode_q;

  // Output level from the position within the current period
  always_comb begin
    phase  = (down_q == 16'd0) ? 17'd0 : (reload_q - {1'b0, down_q});
    rel_p1 = {1'b0, reload_q} + 18'd1;
    rel_m1 = reload_q - 17'd1;
    level  = 1'b0;
    if (reload_q != 17'd0) begin
      case (eff_mode)
        3'd0: level = 1'b1;
        3'd1: level = 1'b0;
        3'd2: level = (phase != 17'd1);
        3'd3: begin
          if (reload_q[0]) level = (phase >= rel_p1[17:1]);
          else             level = (phase < {1'b0, rel_m1[16:1]});
        end
        default: level = (phase != 17'd0);
      endcase
    end
  end

  // Assemble the reload word from the byte sequence
  always_comb begin
    load_val = {8'h00, ctl_i.wdata};
    do_load  = 1'b0;
    case (wph_q)
      2'd0: begin
        load_val = {8'h00, ctl_i.wdata};
        do_load  = ctl_i.data_wr;
      end
      2'd1: begin
        load_val = {ctl_i.wdata, 8'h00};
        do_load  = ctl_i.data_wr;
      end
      2'd2: begin
        load_val = {8'h00, ctl_i.wdata};
        do_load  = 1'b0;
      end
      default: begin
        load_val = {ctl_i.wdata, low_q};
        do_load  = ctl_i.data_wr;
      end
    endcase
  end

  // Next state for the current word
  always_comb begin
    reload_d = reload_q;
    down_d   = down_q;
    mode_d   = mode_q;
    bcd_d    = bcd_q;
    acc_d    = acc_q;
    wph_d    = wph_q;
    rph_d    = rph_q;
    low_d    = low_q;
    lf_d     = lf_q;
    shold_d  = shold_q;
    chold_d  = chold_q;
    rdata    = BYTE_NONE;

    // Count down, wrapping to reload minus one
    if (ctl_i.tick && reload_q != 17'd0) begin
      down_d = (down_q == 16'd0) ? rel_m1[15:0] : (down_q - 16'd1);
    end

    // Reload byte writes
    if (ctl_i.data_wr) begin
      if (wph_q == 2'd2) begin
        low_d = ctl_i.wdata;
        wph_d = 2'd3;
      end else if (wph_q == 2'd3) begin
        wph_d = 2'd2;
      end
    end
    if (do_load) begin
      reload_d = (load_val == 16'd0) ? 17'h10000 : {1'b0, load_val};
      down_d   = 16'd0;
    end

    // Program mode and access from a control word
    if (ctl_i.cw_prog) begin
      acc_d  = ctl_i.wdata[5:4];
      wph_d  = ctl_i.wdata[5:4] - 2'd1;
      rph_d  = ctl_i.wdata[5:4] - 2'd1;
      mode_d = ctl_i.wdata[3:1];
      bcd_d  = ctl_i.wdata[0];
    end

    // Latch count unless one is still held
    if (ctl_i.cnt_latch && !lf_q[1]) begin
      lf_d[3:2] = acc_q;
      lf_d[1]   = 1'b1;
      case (acc_q)
        2'd1:    chold_d = {8'h00, down_q[7:0]};
        2'd2:    chold_d = {8'h00, down_q[15:8]};
        2'd3:    chold_d = down_q;
        default: chold_d = chold_q;
      endcase
    end

    // Latch status unless one is still held; bit 6 reads as zero
    if (ctl_i.sts_latch && !lf_q[0]) begin
      shold_d = {level, 1'b0, acc_q, mode_q, bcd_q};
      lf_d[0] = 1'b1;
    end

    // Reads: status latch, then count latch, then live count
    if (ctl_i.data_rd) begin
      if (lf_q[0]) begin
        lf_d[0] = 1'b0;
        rdata   = shold_q;
      end else if (lf_q[1]) begin
        case (lf_q[3:2])
          2'd1, 2'd2: begin
            rdata = chold_q[7:0];
            lf_d  = 4'b0000;
          end
          2'd3: begin
            rdata   = chold_q[7:0];
            chold_d = {8'h00, chold_q[15:8]};
            lf_d    = 4'b1010;
          end
          default: lf_d = 4'b0000;
        endcase
      end else begin
        case (rph_q)
          2'd0: rdata = down_q[7:0];
          2'd1: rdata = down_q[15:8];
          default: begin
            rdata    = rph_q[0] ? down_q[15:8] : down_q[7:0];
            rph_d[0] = ~rph_q[0];
          end
        endcase
      end
    end
  end

  // Hold channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      down_q   <= '0;
      mode_q   <= '0;
      bcd_q    <= 1'b0;
      acc_q    <= '0;
      wph_q    <= '0;
      rph_q    <= '0;
      low_q    <= '0;
      lf_q     <= '0;
      shold_q  <= '0;
      chold_q  <= '0;
    end else begin
      reload_q <= reload_d;
      down_q   <= down_d;
      mode_q   <= mode_d;
      bcd_q    <= bcd_d;
      acc_q    <= acc_d;
      wph_q    <= wph_d;
      rph_q    <= rph_d;
      low_q    <= low_d;
      lf_q     <= lf_d;
      shold_q  <= shold_d;
      chold_q  <= chold_d;
    end
  end

  // Report to the decoder
  always_comb begin
    sts_o.rdata    = rdata;
    sts_o.level    = level;
    sts_o.wrap     = ctl_i.tick && reload_q != 17'd0 && down_q == 16'd0 &&
                     rel_m1[15:0] != 16'd0;
    sts_o.load     = do_load;
    sts_o.eff_mode = eff_mode;
  end

endmodule

[rtl/interval_timer_three_channel.sv]
// Top level of the three-channel interval timer: decode, channel 0 interrupt, speaker.
// Depends on itt_pkg and itt_chan.
//
//   channel | direction | signals                          | word
//   in      | sink      | in_valid_i, in_ready_o           | cmd_i, port_i, wdata_i
//   out     | source    | out_valid_o, out_ready_i         | rdata_o, irq_raise_o
//
// For every accepted word, decode and all channel updates happen at the accepting edge and
// the result word appears in the output register the cycle after.
// A new word is accepted every cycle while the output register is empty or drained.
// While out_ready_i is low with a word held, in_ready_o is low.
// Reset clears all channel state, the interrupt run flag and the speaker toggle.
module interval_timer_three_channel (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [1:0] port_i,
  input  logic [7:0] wdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] rdata_o,
  output logic       irq_raise_o
);
  import itt_pkg::*;

  logic       in_acc;
  logic       is_wr, is_rd, is_tick, is_spkr, is_cw;
  logic [1:0] cw_sel, cw_acc;
  logic [2:0] cw_mode;

  chan_ctl_t ctl [NumChan];
  chan_sts_t sts [NumChan];

  logic       run_q, run_d;
  logic       spk_q, spk_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] rdata_q, rdata_d;
  logic       irq_q, irq_d;
  logic       irq_cw, irq_tick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode the word
  assign is_wr   = in_acc && (cmd_i == CMD_WRITE);
  assign is_rd   = in_acc && (cmd_i == CMD_READ);
  assign is_tick = in_acc && (cmd_i == CMD_TICK);
  assign is_spkr = in_acc && (cmd_i == CMD_SPKR);
  assign is_cw   = is_wr && (port_i == CW_PORT);
  assign cw_sel  = wdata_i[7:6];
  assign cw_acc  = wdata_i[5:4];
  assign cw_mode = wdata_i[3:1];

  // Fan strobes out to the channels
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    always_comb begin
      ctl[c].tick      = is_tick;
      ctl[c].data_wr   = is_wr && (port_i == 2'(c));
      ctl[c].data_rd   = is_rd && (port_i == 2'(c));
      ctl[c].cw_prog   = is_cw && (cw_sel == 2'(c)) && (cw_acc != ACC_LATCH);
      ctl[c].cnt_latch = is_cw && (((cw_sel == 2'(c)) && (cw_acc == ACC_LATCH)) ||
                         ((cw_sel == SEL_READBACK) && cw_mode[c] && !cw_acc[1]));
      ctl[c].sts_latch = is_cw && (cw_sel == SEL_READBACK) && cw_mode[c] && !cw_acc[0];
      ctl[c].wdata     = wdata_i;
    end

    itt_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[c]),
      .sts_o  (sts[c])
    );
  end

  // Channel 0 interrupt: mode-2 control word, or a wrap while running
  assign irq_cw   = is_cw && (cw_sel == 2'd0) && (cw_acc != ACC_LATCH) &&
                    (cw_mode == 3'd2 || cw_mode == 3'd6);
  assign irq_tick = run_q && sts[0].wrap;

  always_comb begin
    run_d = run_q;
    if (sts[0].load) begin
      run_d = 1'b1;
    end else if (irq_tick && sts[0].eff_mode != 3'd2 && sts[0].eff_mode != 3'd3) begin
      run_d = 1'b0;
    end
  end

  // Speaker toggle flips on each speaker read
  assign spk_d = is_spkr ? ~spk_q : spk_q;

  // Select the result byte
  always_comb begin
    rdata_d = BYTE_NONE;
    case (cmd_i)
      CMD_READ: begin
        case (port_i)
          2'd0:    rdata_d = sts[0].rdata;
          2'd1:    rdata_d = sts[1].rdata;
          2'd2:    rdata_d = sts[2].rdata;
          default: rdata_d = BYTE_NONE;
        endcase
      end
      CMD_SPKR: rdata_d = {2'b00, sts[2].level, spk_d, 4'h0};
      default:  rdata_d = BYTE_NONE;
    endcase
    irq_d = irq_cw || irq_tick;
  end

  // Advance or drop the output word
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      spk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      spk_q       <= spk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = rdata_q;
  assign irq_raise_o = irq_q;

  // Reads and speaker reads never raise the interrupt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CMD_READ || cmd_i == CMD_SPKR)) |=> !irq_raise_o)
    else $error("interrupt raised on a read word");

  // Writes and ticks return the empty byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CMD_WRITE || cmd_i == CMD_TICK)) |=> (rdata_o == BYTE_NONE))
    else $error("write or tick returned data");

  // Every accepted word shows up in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word lost");

  // Speaker toggle moves only on speaker reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_spkr |=> $stable(spk_q))
    else $error("speaker toggle changed without a speaker read");

endmodule

[bench/timer_word_checker.sv]
`timescale 1ns / 1ps
// Checker for the three-channel interval timer: predicts each result word and compares.
// Depends on itt_pkg; watches both valid/ready channels of the timer from outside.
module timer_word_checker
  import itt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] cmd_i,
  input  logic [1:0] port_i,
  input  logic [7:0] wdata_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] rdata_i,
  input  logic       irq_raise_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         irq_count_o
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } timer_word_t;

  // Result words still owed by the timer, oldest first
  timer_word_t expected_words[$];

  // Predicted timer state
  logic [16:0] reload_val  [NumChan];
  logic [15:0] cur_count   [NumChan];
  logic [2:0]  op_mode     [NumChan];
  logic        bcd_bit     [NumChan];
  logic [1:0]  acc_mode    [NumChan];
  logic [1:0]  wr_phase    [NumChan];
  logic [1:0]  rd_phase    [NumChan];
  logic [7:0]  low_byte    [NumChan];
  logic [3:0]  latch_state [NumChan];
  logic [7:0]  status_byte [NumChan];
  logic [15:0] held_count  [NumChan];
  logic        chan0_armed;
  logic        spkr_toggle;

  function automatic void clear_timer_state();
    for (int i = 0; i < NumChan; i++) begin
      reload_val[i]  = '0;
      cur_count[i]   = '0;
      op_mode[i]     = '0;
      bcd_bit[i]     = '0;
      acc_mode[i]    = '0;
      wr_phase[i]    = '0;
      rd_phase[i]    = '0;
      low_byte[i]    = '0;
      latch_state[i] = '0;
      status_byte[i] = '0;
      held_count[i]  = '0;
    end
    chan0_armed = 1'b0;
    spkr_toggle = 1'b0;
  endfunction

  // Modes six and seven behave as two and three
  function automatic logic [2:0] eff_mode(int c);
    return (op_mode[c] >= 3'd6) ? op_mode[c] - 3'd4 : op_mode[c];
  endfunction

  function automatic logic out_level(int c);
    int unsigned r, d, p;
    logic lvl;
    r = reload_val[c];
    d = cur_count[c];
    p = (d == 0) ? 0 : r - d;
    case (eff_mode(c))
      3'd0: lvl = 1'b1;
      3'd1: lvl = 1'b0;
      3'd2: lvl = (p != 1);
      3'd3: begin
        if (r % 2 == 1) lvl = (p >= (r + 1) / 2);
        else lvl = (p < (r - 1) / 2);
      end
      default: lvl = (p != 0);
    endcase
    if (r == 0) lvl = 1'b0;
    return lvl;
  endfunction

  // A written zero stands for 65536; the counter restarts from zero
  function automatic void load_reload(int c, logic [15:0] v);
    reload_val[c] = (v == 16'd0) ? 17'h10000 : {1'b0, v};
    cur_count[c]  = '0;
    if (c == 0) chan0_armed = 1'b1;
  endfunction

  // Hold the count as the access mode says; a held count is not replaced
  function automatic void latch_count(int c);
    if (latch_state[c][1]) return;
    latch_state[c] = {acc_mode[c], 1'b1, latch_state[c][0]};
    case (acc_mode[c])
      2'd1:    held_count[c] = {8'h00, cur_count[c][7:0]};
      2'd2:    held_count[c] = {8'h00, cur_count[c][15:8]};
      2'd3:    held_count[c] = cur_count[c];
      default: ;
    endcase
  endfunction

  function automatic logic port_write(int port, logic [7:0] v);
    logic       irq;
    logic [1:0] sel;
    logic [1:0] acc;
    logic [2:0] md;
    irq = 1'b0;
    sel = v[7:6];
    acc = v[5:4];
    md  = v[3:1];
    if (port == CW_PORT) begin
      if (sel == SEL_READBACK) begin
        for (int i = 0; i < NumChan; i++) begin
          if (md[i]) begin
            if (!acc[1]) latch_count(i);
            if (!acc[0] && !latch_state[i][0]) begin
              status_byte[i] = {out_level(i), 1'b0, acc_mode[i], op_mode[i], bcd_bit[i]};
              latch_state[i][0] = 1'b1;
            end
          end
        end
      end else if (acc == ACC_LATCH) begin
        latch_count(sel);
      end else begin
        acc_mode[sel] = acc;
        wr_phase[sel] = acc - 2'd1;
        rd_phase[sel] = acc - 2'd1;
        op_mode[sel]  = md;
        bcd_bit[sel]  = v[0];
        if (sel == 2'd0 && eff_mode(0) == 3'd2) irq = 1'b1;
      end
    end else begin
      case (wr_phase[port])
        2'd0: load_reload(port, {8'h00, v});
        2'd1: load_reload(port, {v, 8'h00});
        2'd2: begin
          low_byte[port] = v;
          wr_phase[port] = 2'd3;
        end
        default: begin
          load_reload(port, {v, low_byte[port]});
          wr_phase[port] = 2'd2;
        end
      endcase
    end
    return irq;
  endfunction

  function automatic logic [7:0] port_read(int c);
    logic [7:0] r;
    logic [1:0] how;
    r = BYTE_NONE;
    if (c == CW_PORT) return BYTE_NONE;
    if (latch_state[c][0]) begin
      latch_state[c][0] = 1'b0;
      r = status_byte[c];
    end else if (latch_state[c][1]) begin
      how = latch_state[c][3:2];
      if (how == 2'd1 || how == 2'd2) begin
        r = held_count[c][7:0];
        latch_state[c] = '0;
      end else if (how == 2'd3) begin
        // Low byte first, then leave the high byte held as a single-byte latch
        r = held_count[c][7:0];
        held_count[c] = held_count[c] >> 8;
        latch_state[c] = 4'b1010;
      end else begin
        latch_state[c] = '0;
      end
    end else begin
      case (rd_phase[c])
        2'd0: r = cur_count[c][7:0];
        2'd1: r = cur_count[c][15:8];
        default: begin
          r = rd_phase[c][0] ? cur_count[c][15:8] : cur_count[c][7:0];
          rd_phase[c][0] = ~rd_phase[c][0];
        end
      endcase
    end
    return r;
  endfunction

  // Advance every loaded channel; channel 0 wraps while armed raise the interrupt
  function automatic logic tick_all();
    logic        irq;
    logic [15:0] old0;
    logic [16:0] top;
    logic [2:0]  m;
    irq  = 1'b0;
    old0 = cur_count[0];
    for (int i = 0; i < NumChan; i++) begin
      if (reload_val[i] != 17'd0) begin
        top = reload_val[i] - 17'd1;
        if (cur_count[i] == 16'd0) cur_count[i] = top[15:0];
        else cur_count[i] = cur_count[i] - 16'd1;
      end
    end
    if (chan0_armed && cur_count[0] > old0) begin
      irq = 1'b1;
      m = eff_mode(0);
      if (m != 3'd2 && m != 3'd3) chan0_armed = 1'b0;
    end
    return irq;
  endfunction

  function automatic timer_word_t timer_step(cmd_e cmd, logic [1:0] port, logic [7:0] data);
    timer_word_t w;
    w.rdata = BYTE_NONE;
    w.irq   = 1'b0;
    case (cmd)
      CMD_WRITE: w.irq = port_write(port, data);
      CMD_READ:  w.rdata = port_read(port);
      CMD_TICK:  w.irq = tick_all();
      default: begin
        spkr_toggle = ~spkr_toggle;
        w.rdata = {2'b00, out_level(2), spkr_toggle, 4'h0};
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0d ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // Compare the drained word first, then predict the word just taken in
  always @(posedge clk_i or negedge rst_ni) begin
    timer_word_t want;
    if (!rst_ni) begin
      clear_timer_state();
      expected_words.delete();
      fail_count_o = 0;
      irq_count_o  = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word rdata=%02h irq=%b with nothing expected",
                                    rdata_i, irq_raise_i));
        end else begin
          want = expected_words.pop_front();
          if (rdata_i !== want.rdata)
            report_mismatch($sformatf("rdata %02h, expected %02h", rdata_i, want.rdata));
          if (irq_raise_i !== want.irq)
            report_mismatch($sformatf("irq_raise %b, expected %b", irq_raise_i, want.irq));
          if (want.irq) irq_count_o++;
        end
      end
      if (in_valid_i && in_ready_i)
        expected_words.push_back(timer_step(cmd_e'(cmd_i), port_i, wdata_i));
      pending_o = expected_words.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the interval timer testbench: clock, reset, stimulus phases and verdict.
// Depends on itt_pkg, interval_timer_three_channel and timer_word_checker.
module tb;
  import itt_pkg::*;

  localparam int unsigned RandomWords = 950;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned CycleLimit  = 200_000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [1:0] port_i = '0;
  logic [7:0] wdata_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] rdata_o;
  logic       irq_raise_o;

  int fail_count;
  int pending_words;
  int irq_count;

  int unsigned words_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned idle_by_phase  [NumPhases] = '{0, 53, 0, 9};
  int unsigned stall_by_phase [NumPhases] = '{0, 0, 53, 9};

  interval_timer_three_channel DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .port_i,
    .wdata_i,
    .out_valid_o,
    .out_ready_i,
    .rdata_o,
    .irq_raise_o
  );

  timer_word_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .cmd_i,
    .port_i,
    .wdata_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .rdata_i      (rdata_o),
    .irq_raise_i  (irq_raise_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_words),
    .irq_count_o  (irq_count)
  );

  always #10 clk_i = ~clk_i;

  // Stall the result channel at the current rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycles, pending_words);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] cw_byte(logic [1:0] sel, logic [1:0] acc, logic [2:0] md,
                                         logic bcd);
    return {sel, acc, md, bcd};
  endfunction

  // Present one word and hold it until taken; called and returns at a rising edge
  task automatic send_word(cmd_e cmd, logic [1:0] port, logic [7:0] data);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    port_i     <= port;
    wdata_i    <= data;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    words_sent++;
  endtask

  // Hold off the sender until every owed word has drained
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    @(posedge clk_i);
  endtask

  task automatic directed_words();
    // Latch before any access mode is set: the read gives the empty byte
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd1, ACC_LATCH, 3'd0, 1'b0));
    send_word(CMD_READ, 2'd1, 8'h00);
    send_word(CMD_READ, CW_PORT, 8'hFF);
    send_word(CMD_SPKR, 2'd0, 8'h00);
    // Channel 0 in rate mode, low then high byte; the mode word itself raises an IRQ
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd0, 2'd3, 3'd2, 1'b0));
    send_word(CMD_WRITE, 2'd0, 8'h03);
    send_word(CMD_WRITE, 2'd0, 8'h00);
    repeat (4) send_word(CMD_TICK, 2'd0, 8'h00);
    // Channel 1 in mode seven with BCD, low byte only, zero loads 65536
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd1, 2'd1, 3'd7, 1'b1));
    send_word(CMD_WRITE, 2'd1, 8'h00);
    // Channel 2 square wave, high byte only
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd2, 2'd2, 3'd3, 1'b0));
    send_word(CMD_WRITE, 2'd2, 8'hFF);
    send_word(CMD_TICK, 2'd3, 8'hFF);
    // Repeated count latch keeps the first one
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd0, ACC_LATCH, 3'd0, 1'b0));
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd0, ACC_LATCH, 3'd0, 1'b0));
    // Read-back of status and count on all channels
    send_word(CMD_WRITE, CW_PORT, cw_byte(SEL_READBACK, 2'd0, 3'd7, 1'b0));
    repeat (3) send_word(CMD_READ, 2'd0, 8'h00);
    send_word(CMD_READ, 2'd2, 8'h00);
    // Reload of one never wraps
    send_word(CMD_WRITE, CW_PORT, cw_byte(2'd0, 2'd1, 3'd0, 1'b0));
    send_word(CMD_WRITE, 2'd0, 8'h01);
    repeat (2) send_word(CMD_TICK, 2'd0, 8'h00);
    send_word(CMD_SPKR, 2'd3, 8'hFF);
  endtask

  // One short sequence: mostly program-load-tick-read flows, some noise
  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    logic [1:0]  ch;
    logic [1:0]  acc;
    logic [15:0] val;
    pick = $urandom_range(99);
    ch   = 2'($urandom_range(2));
    if (pick < 35) begin
      acc = 2'($urandom_range(3, 1));
      send_word(CMD_WRITE, CW_PORT,
                cw_byte(ch, acc, 3'($urandom_range(7)), 1'($urandom_range(1))));
      val = ($urandom_range(99) < 80) ? 16'($urandom_range(24, 1))
                                      : 16'($urandom_range(16'hFFFF));
      send_word(CMD_WRITE, ch, val[7:0]);
      if (acc == 2'd3) send_word(CMD_WRITE, ch, val[15:8]);
    end else if (pick < 60) begin
      n = $urandom_range(16, 1);
      repeat (n) send_word(CMD_TICK, 2'($urandom_range(3)), 8'($urandom));
    end else if (pick < 70) begin
      send_word(CMD_WRITE, CW_PORT, cw_byte(ch, ACC_LATCH, 3'($urandom_range(7)),
                                            1'($urandom_range(1))));
      n = $urandom_range(3, 1);
      repeat (n) send_word(CMD_READ, ch, 8'($urandom));
    end else if (pick < 80) begin
      send_word(CMD_WRITE, CW_PORT, cw_byte(SEL_READBACK, 2'($urandom_range(3)),
                                            3'($urandom_range(7, 1)), 1'($urandom_range(1))));
      n = $urandom_range(4, 1);
      repeat (n) send_word(CMD_READ, 2'($urandom_range(2)), 8'($urandom));
    end else if (pick < 90) begin
      n = $urandom_range(4, 1);
      repeat (n) begin
        if ($urandom_range(3) == 0) send_word(CMD_SPKR, 2'($urandom_range(3)), 8'($urandom));
        else send_word(CMD_READ, 2'($urandom_range(3)), 8'($urandom));
      end
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) send_word(cmd_e'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom));
    end
  endtask

  initial begin
    int unsigned directed_count;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_words();
    directed_count = words_sent;
    drain();

    // Random phases with different idle and stall rates
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct <= stall_by_phase[ph];
      while (words_sent < directed_count + (ph + 1) * RandomWords / NumPhases)
        random_sequence();
      drain();
    end

    stall_pct <= 0;
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d words (%0d directed) over %0d idle/stall phases in %0d cycles",
             words_sent, directed_count, NumPhases, cycles);
    $display("Channel 0 raised %0d interrupts; %0d mismatches", irq_count, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
